FILE: design/rpcd_pkg.sv
// rpcd_pkg: types and constants shared by the run-length pixel-map clip decoder
// holds the configuration and span structs, the decode phase and register index codes
// no dependencies

package rpcd_pkg;

	localparam int MAX_DIMENSION = 4096;

	localparam int CFG_DATA_W  = 12;
	localparam int CFG_INDEX_W = 3;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_REPEAT  = 2'd1,
		PH_LITERAL = 2'd2
	} phase_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ALPHA_MODE     = 3'd0,
		REG_OPACITY        = 3'd1,
		REG_IMAGE_WIDTH    = 3'd2,
		REG_CLIP_COL_FIRST = 3'd3,
		REG_CLIP_COL_LAST  = 3'd4,
		REG_CLIP_ROW_FIRST = 3'd5,
		REG_CLIP_ROW_LAST  = 3'd6
	} cfg_index_t;

	typedef struct packed {
		logic        alpha_mode;
		logic [7:0]  opacity;
		logic [11:0] image_width;
		logic [11:0] clip_col_first;
		logic [11:0] clip_col_last;
		logic [11:0] clip_row_first;
		logic [11:0] clip_row_last;
	} cfg_t;

	typedef struct packed {
		logic        emit;
		logic [11:0] row;
		logic [11:0] col;
		logic [12:0] length;
		logic [7:0]  color;
		logic [7:0]  alpha;
		logic        direct_write;
	} span_t;

endpackage

FILE: design/rle_pixmap_clip_decoder_top.sv
// rle_pixmap_clip_decoder_top: run-length pixel-map decoder with rectangle clipping
// a code word transaction loads the input register; its decoded span is then captured in the
// span register
// throughput: one code word per cycle while the output side is not stalled, set by the decode state update
// the span register decouples the output side; a stall there holds the input register
// reset: asynchronous, clears decode state, valids and configuration to defaults
// depends on rpcd_pkg and rpcd_decode

module rle_pixmap_clip_decoder_top
	import rpcd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   code_valid,
	output logic                   code_ready,
	input  logic [15:0]            code_word,
	input  logic                   image_start,
	output logic                   span_valid,
	input  logic                   span_ready,
	output logic [11:0]            span_row,
	output logic [11:0]            span_col,
	output logic [12:0]            span_length,
	output logic [7:0]             span_color,
	output logic [7:0]             span_alpha,
	output logic                   direct_write
);

	cfg_t        cfg_q;
	logic        valid_s1;
	logic [15:0] word_s1;
	logic        start_s1;
	logic        out_free;
	logic        fire;
	span_t       span;
	span_t       span_q;
	logic        span_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha_mode     <= 1'b0;
			cfg_q.opacity        <= 8'hff;
			cfg_q.image_width    <= 12'd1;
			cfg_q.clip_col_first <= 12'd0;
			cfg_q.clip_col_last  <= 12'hfff;
			cfg_q.clip_row_first <= 12'd0;
			cfg_q.clip_row_last  <= 12'hfff;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ALPHA_MODE:     cfg_q.alpha_mode     <= cfg_data[0];
				REG_OPACITY:        cfg_q.opacity        <= cfg_data[7:0];
				REG_IMAGE_WIDTH:    cfg_q.image_width    <= cfg_data;
				REG_CLIP_COL_FIRST: cfg_q.clip_col_first <= cfg_data;
				REG_CLIP_COL_LAST:  cfg_q.clip_col_last  <= cfg_data;
				REG_CLIP_ROW_FIRST: cfg_q.clip_row_first <= cfg_data;
				REG_CLIP_ROW_LAST:  cfg_q.clip_row_last  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free   = !span_valid_q || span_ready;
	assign fire       = valid_s1 && out_free;
	assign code_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (code_ready) begin
			valid_s1 <= code_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (code_valid && code_ready) begin
			word_s1  <= code_word;
			start_s1 <= image_start;
		end
	end

	rpcd_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.word   (word_s1),
		.start  (start_s1),
		.cfg    (cfg_q),
		.span   (span)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_valid_q <= 1'b0;
		end else if (out_free) begin
			span_valid_q <= span.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (span.emit) begin
			span_q <= span;
		end
	end

	assign span_valid   = span_valid_q;
	assign span_row     = span_q.row;
	assign span_col     = span_q.col;
	assign span_length  = span_q.length;
	assign span_color   = span_q.color;
	assign span_alpha   = span_q.alpha;
	assign direct_write = span_q.direct_write;

endmodule

FILE: design/rpcd_decode.sv
// rpcd_decode: run-length decode state, row and column tracking, clipping and alpha scaling
// one code word is consumed per cycle in which fire is high
// depends on rpcd_pkg

module rpcd_decode
	import rpcd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic [15:0] word,
	input  logic        start,
	input  cfg_t        cfg,
	output span_t       span
);

	phase_t      phase_q;
	logic [15:0] run_q;
	logic [16:0] col_q;
	logic [12:0] row_q;
	logic        fin_q;

	phase_t      phase_e, phase_n;
	logic [15:0] run_e, run_n;
	logic [16:0] col_e, col_n;
	logic [12:0] row_e, row_n;
	logic        fin_e, fin_n;

	logic        is_pixel;
	logic        is_repeat;
	logic [15:0] count;
	logic [7:0]  pix_alpha;
	logic [15:0] prod;
	logic [16:0] scaled;
	logic [7:0]  alpha;
	logic        show;
	logic [17:0] last;
	logic [16:0] lo;
	logic [11:0] hi;
	logic        fits;
	logic [16:0] col_adv;
	logic [12:0] row_inc;
	logic        run_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			run_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
			fin_q   <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_n;
			run_q   <= run_n;
			col_q   <= col_n;
			row_q   <= row_n;
			fin_q   <= fin_n;
		end
	end

	// new image clears position and run state before the word is decoded
	always_comb begin
		if (start) begin
			phase_e = PH_HEADER;
			run_e   = '0;
			col_e   = '0;
			row_e   = '0;
			fin_e   = 1'b0;
		end else begin
			phase_e = phase_q;
			run_e   = run_q;
			col_e   = col_q;
			row_e   = row_q;
			fin_e   = fin_q;
		end
	end

	always_comb begin
		unique case (phase_e)
			PH_REPEAT:  begin is_pixel = 1'b1; is_repeat = 1'b1; end
			PH_LITERAL: begin is_pixel = 1'b1; is_repeat = 1'b0; end
			default:    begin is_pixel = 1'b0; is_repeat = 1'b0; end
		endcase
	end

	assign count     = is_repeat ? run_e : 16'd1;
	assign pix_alpha = word[15:8];
	assign prod      = pix_alpha * cfg.opacity;
	// exact divide by 255 for the product of two 8-bit values
	assign scaled    = (17'(prod) + 17'(prod[15:8]) + 17'd1) >> 8;

	always_comb begin
		if (cfg.alpha_mode) begin
			alpha = (cfg.opacity == 8'hff) ? pix_alpha : scaled[7:0];
			show  = (pix_alpha != 8'd0);
		end else begin
			alpha = cfg.opacity;
			show  = 1'b1;
		end
		if (cfg.opacity == 8'd0)
			show = 1'b0;
		if (row_e < {1'b0, cfg.clip_row_first} || row_e > {1'b0, cfg.clip_row_last})
			show = 1'b0;
	end

	assign last = {1'b0, col_e} + {2'b0, count} - 18'd1;
	assign lo   = (col_e > {5'b0, cfg.clip_col_first}) ? col_e : {5'b0, cfg.clip_col_first};
	assign hi   = (last < {6'b0, cfg.clip_col_last}) ? last[11:0] : cfg.clip_col_last;
	assign fits = (lo <= {5'b0, hi});

	always_comb begin
		span.emit         = fire && !fin_e && is_pixel && show && (count != 16'd0) && fits;
		span.row          = row_e[11:0];
		span.col          = lo[11:0];
		span.length       = {1'b0, hi} - {1'b0, lo[11:0]} + 13'd1;
		span.color        = word[7:0];
		span.alpha        = alpha;
		span.direct_write = !cfg.alpha_mode && (cfg.opacity == 8'hff);
	end

	assign col_adv  = col_e + {1'b0, count};
	assign row_inc  = row_e + 13'd1;
	assign run_done = is_repeat || (run_e <= 16'd1);

	always_comb begin
		phase_n = phase_e;
		run_n   = run_e;
		col_n   = col_e;
		row_n   = row_e;
		fin_n   = fin_e;
		if (!fin_e) begin
			if (!is_pixel) begin
				if (cfg.alpha_mode) begin
					run_n   = {1'b0, word[14:0]} + 16'd1;
					phase_n = word[15] ? PH_REPEAT : PH_LITERAL;
				end else begin
					run_n   = {9'b0, word[6:0]} + 16'd1;
					phase_n = word[7] ? PH_REPEAT : PH_LITERAL;
				end
			end else begin
				col_n = col_adv;
				if (run_done) begin
					run_n   = '0;
					phase_n = PH_HEADER;
					if (col_adv >= {5'b0, cfg.image_width}) begin
						col_n = '0;
						row_n = row_inc;
						if (row_inc > {1'b0, cfg.clip_row_last}
							|| 32'(row_inc) >= MAX_DIMENSION)
							fin_n = 1'b1;
					end
				end else begin
					run_n = run_e - 16'd1;
				end
			end
		end
	end

endmodule

FILE: design/rpcd_checker.sv
// rpcd_checker: port-level checks on the span output of the decoder top level
// bound to rle_pixmap_clip_decoder_top; no package dependency

module rpcd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        code_valid,
	input logic        code_ready,
	input logic        span_valid,
	input logic        span_ready,
	input logic [11:0] span_row,
	input logic [11:0] span_col,
	input logic [12:0] span_length,
	input logic [7:0]  span_color,
	input logic [7:0]  span_alpha,
	input logic        direct_write
);

	// stalled span transaction stays put
	a_span_hold: assert property (@(posedge clk) disable iff (!arst_n)
		span_valid && !span_ready |=> span_valid && $stable(span_row) && $stable(span_col)
			&& $stable(span_length) && $stable(span_color) && $stable(span_alpha))
		else $error("span transaction changed while stalled");

	// visible span stays inside the column range
	a_span_extent: assert property (@(posedge clk) disable iff (!arst_n)
		span_valid |-> span_length != 13'd0 && ({1'b0, span_col} + span_length) <= 13'd4096)
		else $error("span extends beyond the column range");

	// plain stores are always fully opaque
	a_direct_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		span_valid && direct_write |-> span_alpha == 8'hff)
		else $error("direct write with partial alpha");

	// with no span shown, no code word transaction and code_ready low, no span may then appear
	a_no_early_span: assert property (@(posedge clk) disable iff (!arst_n)
		!span_valid && !(code_valid && code_ready) && !code_ready |=> !span_valid)
		else $error("span appeared without input");

endmodule

bind rle_pixmap_clip_decoder_top rpcd_checker u_rpcd_checker (.*);

FILE: bench/tb_top.sv
// tb_top: self-checking bench for rle_pixmap_clip_decoder_top, a run-length pixel-map
// decoder with clipping; the span_scoreboard class predicts and checks the clipped spans
// depends on rpcd_pkg and the design sources

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rpcd_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int RANDOM_WORDS = 1500;
	localparam int HOLD_CYCLES  = 300;
	localparam int IDLE_PCT     = 22;
	localparam int DRAIN_CYCLES = 8;

	localparam logic [7:0]  BYTE_REPEAT_FLAG = 8'h80;
	localparam logic [15:0] WORD_REPEAT_FLAG = 16'h8000;

	class span_scoreboard;
		cfg_t        setting;
		phase_t      phase;
		logic [15:0] run_left;
		logic [16:0] col_pos;
		logic [12:0] row_pos;
		logic        finished;
		span_t       spans_due[$];
		int          errors;
		int          spans_checked;
		int          words_decoded;

		function new();
			setting = '{alpha_mode: 1'b0, opacity: 8'hff, image_width: 12'd1,
				clip_col_first: 12'd0, clip_col_last: 12'hfff,
				clip_row_first: 12'd0, clip_row_last: 12'hfff};
			clear_image();
		endfunction

		function void clear_image();
			phase    = PH_HEADER;
			run_left = '0;
			col_pos  = '0;
			row_pos  = '0;
			finished = 1'b0;
		endfunction

		function void set_reg(cfg_index_t r, logic [11:0] v);
			case (r)
				REG_ALPHA_MODE:     setting.alpha_mode     = v[0];
				REG_OPACITY:        setting.opacity        = v[7:0];
				REG_IMAGE_WIDTH:    setting.image_width    = v;
				REG_CLIP_COL_FIRST: setting.clip_col_first = v;
				REG_CLIP_COL_LAST:  setting.clip_col_last  = v;
				REG_CLIP_ROW_FIRST: setting.clip_row_first = v;
				REG_CLIP_ROW_LAST:  setting.clip_row_last  = v;
				default: ;
			endcase
		endfunction

		function int pending();
			return spans_due.size();
		endfunction

		// a row ends only when a run completes at or past the image width
		function void end_run();
			phase = PH_HEADER;
			if (col_pos >= 17'(setting.image_width)) begin
				col_pos = '0;
				row_pos = row_pos + 13'd1;
				if (row_pos > 13'(setting.clip_row_last) || row_pos >= 13'(MAX_DIMENSION))
					finished = 1'b1;
			end
		endfunction

		function void note_code_word(logic [15:0] w, logic start);
			int unsigned count;
			int unsigned alpha;
			int unsigned lo;
			int unsigned hi;
			int unsigned last;
			logic        show;
			span_t       s;
			if (start)
				clear_image();
			if (finished)
				return;
			words_decoded++;
			if (phase != PH_REPEAT && phase != PH_LITERAL) begin
				if (setting.alpha_mode) begin
					run_left = {1'b0, w[14:0]} + 16'd1;
					phase    = w[15] ? PH_REPEAT : PH_LITERAL;
				end else begin
					run_left = {9'd0, w[6:0]} + 16'd1;
					phase    = w[7] ? PH_REPEAT : PH_LITERAL;
				end
				return;
			end
			count = (phase == PH_REPEAT) ? run_left : 1;
			if (setting.alpha_mode) begin
				alpha = w[15:8];
				show  = (alpha != 0);
				if (setting.opacity != 8'hff)
					alpha = alpha * setting.opacity / 255;
			end else begin
				alpha = setting.opacity;
				show  = 1'b1;
			end
			if (setting.opacity == 8'd0)
				show = 1'b0;
			if (row_pos < setting.clip_row_first || row_pos > setting.clip_row_last)
				show = 1'b0;
			if (show && count != 0) begin
				last = col_pos + count - 1;
				lo   = (col_pos > setting.clip_col_first) ? col_pos : setting.clip_col_first;
				hi   = (last < setting.clip_col_last) ? last : setting.clip_col_last;
				if (lo <= hi) begin
					s.emit         = 1'b1;
					s.row          = row_pos[11:0];
					s.col          = lo[11:0];
					s.length       = 13'(hi - lo + 1);
					s.color        = w[7:0];
					s.alpha        = alpha[7:0];
					s.direct_write = !setting.alpha_mode && setting.opacity == 8'hff;
					spans_due.push_back(s);
				end
			end
			col_pos = 17'(col_pos + count);
			if (phase == PH_REPEAT || run_left <= 16'd1) begin
				run_left = '0;
				end_run();
			end else begin
				run_left = run_left - 16'd1;
			end
		endfunction

		function void compare_field(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				if (errors < 50)
					$display("%0t: span %s mismatch, expected %0d, actual %0d",
						$time, field, want, got);
			end
		endfunction

		function void check_span(span_t got);
			span_t want;
			spans_checked++;
			if (spans_due.size() == 0) begin
				errors++;
				if (errors < 50)
					$display("%0t: span with none expected, actual row %0d col %0d length %0d",
						$time, got.row, got.col, got.length);
				return;
			end
			want = spans_due.pop_front();
			compare_field("row", want.row, got.row);
			compare_field("col", want.col, got.col);
			compare_field("length", want.length, got.length);
			compare_field("color", want.color, got.color);
			compare_field("alpha", want.alpha, got.alpha);
			compare_field("direct_write", want.direct_write, got.direct_write);
		endfunction
	endclass

	logic                   clk         = 1'b0;
	logic                   arst_n      = 1'b0;
	logic                   cfg_we      = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index   = '0;
	logic [CFG_DATA_W-1:0]  cfg_data    = '0;
	logic                   code_valid  = 1'b0;
	logic                   code_ready;
	logic [15:0]            code_word   = '0;
	logic                   image_start = 1'b0;
	logic                   span_valid;
	logic                   span_ready  = 1'b0;
	logic [11:0]            span_row;
	logic [11:0]            span_col;
	logic [12:0]            span_length;
	logic [7:0]             span_color;
	logic [7:0]             span_alpha;
	logic                   direct_write;

	span_scoreboard sb = new();
	span_t          got_span;
	logic           calm          = 1'b0;
	int             hold_requests = 0;
	int             hold_served   = 0;
	int             hold_left     = 0;
	int             cycle_count   = 0;
	int             words_sent    = 0;
	int             settings_used = 0;

	rle_pixmap_clip_decoder_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.code_valid   (code_valid),
		.code_ready   (code_ready),
		.code_word    (code_word),
		.image_start  (image_start),
		.span_valid   (span_valid),
		.span_ready   (span_ready),
		.span_row     (span_row),
		.span_col     (span_col),
		.span_length  (span_length),
		.span_color   (span_color),
		.span_alpha   (span_alpha),
		.direct_write (direct_write)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d spans still due", cycle_count, sb.pending());
			$display("== FAIL ==");
			$finish;
		end
	end

	// span side: check each transaction, then pick ready for the next cycle
	always @(posedge clk) begin
		if (arst_n && span_valid && span_ready) begin
			got_span = '{1'b1, span_row, span_col, span_length, span_color, span_alpha,
				direct_write};
			sb.check_span(got_span);
		end
		if (hold_served < hold_requests && hold_left == 0) begin
			hold_served++;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			span_ready <= 1'b0;
		end else begin
			span_ready <= calm || $urandom_range(99) >= IDLE_PCT;
		end
	end

	function automatic logic [15:0] make_header(logic alpha, logic rep, int unsigned n);
		if (alpha)
			return (rep ? WORD_REPEAT_FLAG : 16'h0000) | 16'((n - 1) & 32'h7fff);
		return {8'($urandom), (rep ? BYTE_REPEAT_FLAG : 8'h00) | 8'((n - 1) & 32'h7f)};
	endfunction

	function automatic logic [15:0] pixel_word();
		logic [15:0] w;
		w = 16'($urandom);
		if (sb.setting.alpha_mode) begin
			case ($urandom_range(9))
				0: w[15:8] = 8'h00;
				1: w[15:8] = 8'hff;
				default: ;
			endcase
		end
		return w;
	endfunction

	function automatic cfg_t random_setting();
		cfg_t c;
		int   w;
		int   x;
		c.alpha_mode = 1'($urandom_range(1));
		case ($urandom_range(5))
			0:       c.opacity = 8'd0;
			1, 2:    c.opacity = 8'hff;
			3:       c.opacity = 8'd1;
			default: c.opacity = 8'($urandom);
		endcase
		case ($urandom_range(15))
			0:       w = 0;
			1:       w = 4095;
			2, 3:    w = 1;
			default: w = $urandom_range(48, 2);
		endcase
		c.image_width = 12'(w);
		case ($urandom_range(7))
			0: begin
				c.clip_col_first = 12'd0;
				c.clip_col_last  = 12'hfff;
			end
			1: begin
				c.clip_col_first = 12'($urandom_range(40, 10));
				c.clip_col_last  = 12'($urandom_range(9, 0));
			end
			default: begin
				c.clip_col_first = 12'($urandom_range(12));
				x = c.clip_col_first + $urandom_range(w < 48 ? 48 : 600);
				c.clip_col_last = (x > 4095) ? 12'hfff : 12'(x);
			end
		endcase
		case ($urandom_range(7))
			0: begin
				c.clip_row_first = 12'd0;
				c.clip_row_last  = 12'hfff;
			end
			1: begin
				c.clip_row_first = 12'd5;
				c.clip_row_last  = 12'd2;
			end
			default: begin
				c.clip_row_first = 12'($urandom_range(3));
				c.clip_row_last  = c.clip_row_first + 12'($urandom_range(24));
			end
		endcase
		return c;
	endfunction

	task automatic program_setting(cfg_t c);
		cfg_index_t  r;
		logic [11:0] v;
		for (int i = 0; i <= REG_CLIP_ROW_LAST; i++) begin
			r = cfg_index_t'(i);
			case (r)
				REG_ALPHA_MODE:     v = {11'($urandom), c.alpha_mode};
				REG_OPACITY:        v = {4'($urandom), c.opacity};
				REG_IMAGE_WIDTH:    v = c.image_width;
				REG_CLIP_COL_FIRST: v = c.clip_col_first;
				REG_CLIP_COL_LAST:  v = c.clip_col_last;
				REG_CLIP_ROW_FIRST: v = c.clip_row_first;
				default:            v = c.clip_row_last;
			endcase
			cfg_we    <= 1'b1;
			cfg_index <= r;
			cfg_data  <= v;
			@(posedge clk);
			sb.set_reg(r, v);
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic send_code(logic [15:0] w, logic start);
		code_valid  <= 1'b1;
		code_word   <= w;
		image_start <= start;
		do @(posedge clk); while (!code_ready);
		sb.note_code_word(w, start);
		words_sent++;
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			code_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
	endtask

	// stop offering words and let every due span come out
	task automatic settle();
		code_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_run(logic first);
		logic        rep;
		logic        alpha;
		int unsigned n;
		alpha = sb.setting.alpha_mode;
		rep   = 1'($urandom_range(1));
		if (rep)
			n = ($urandom_range(3) == 0) ? $urandom_range(alpha ? 32768 : 128, 1)
				: $urandom_range(24, 1);
		else
			n = ($urandom_range(19) == 0) ? (alpha ? 64 : 128) : $urandom_range(6, 1);
		send_code(make_header(alpha, rep, n), first);
		for (int k = 0; k < (rep ? 1 : n); k++) begin
			// occasionally cut a literal run short
			if (!rep && $urandom_range(99) == 0)
				break;
			send_code(pixel_word(), 1'b0);
		end
	endtask

	task automatic send_images(int budget, logic fresh);
		int stop;
		stop = words_sent + budget;
		while (words_sent < stop) begin
			if (sb.finished || $urandom_range(49) == 0)
				fresh = 1'b1;
			if ($urandom_range(29) == 0) begin
				send_code(16'($urandom), 1'($urandom_range(1)));
			end else begin
				send_run(fresh);
				fresh = 1'b0;
			end
		end
	endtask

	initial begin
		cfg_t c;
		int   words_goal;
		int   phase_no;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: byte stream, opaque brush, width one, full clip
		send_code(make_header(1'b0, 1'b1, 1), 1'b1);
		send_code(16'hffe3, 1'b0);
		send_code(make_header(1'b0, 1'b0, 2), 1'b0);
		send_code(16'h0000, 1'b0);
		send_code(16'h12ff, 1'b0);
		send_code(make_header(1'b0, 1'b1, 128), 1'b0);
		send_code(16'h005a, 1'b0);
		send_code(make_header(1'b0, 1'b0, 3), 1'b0);
		send_code(16'h0011, 1'b0);
		send_code(make_header(1'b0, 1'b1, 1), 1'b1);
		send_code(16'h0022, 1'b0);
		settle();

		// alpha words, half brush, narrow clip, single visible row
		c = '{alpha_mode: 1'b1, opacity: 8'd128, image_width: 12'd4095,
			clip_col_first: 12'd5, clip_col_last: 12'd10,
			clip_row_first: 12'd0, clip_row_last: 12'd0};
		program_setting(c);
		send_code(make_header(1'b1, 1'b1, 32768), 1'b1);
		send_code(16'hff3c, 1'b0);
		send_code(make_header(1'b1, 1'b1, 3), 1'b0);
		send_code(16'h00ab, 1'b0);
		send_code(make_header(1'b1, 1'b0, 2), 1'b0);
		send_code(16'h01ff, 1'b0);
		send_code(16'h8000, 1'b0);
		send_code(16'hffff, 1'b0);
		settle();

		// zero width, top row hidden, brush passes pixel alpha
		c = '{alpha_mode: 1'b1, opacity: 8'hff, image_width: 12'd0,
			clip_col_first: 12'd0, clip_col_last: 12'hfff,
			clip_row_first: 12'd1, clip_row_last: 12'hfff};
		program_setting(c);
		send_code(make_header(1'b1, 1'b1, 4), 1'b1);
		send_code(16'h7f01, 1'b0);
		send_code(make_header(1'b1, 1'b0, 1), 1'b0);
		send_code(16'h8001, 1'b0);
		settle();

		// empty column window with a partial brush
		c = '{alpha_mode: 1'b0, opacity: 8'd200, image_width: 12'd4095,
			clip_col_first: 12'd9, clip_col_last: 12'd3,
			clip_row_first: 12'd0, clip_row_last: 12'hfff};
		program_setting(c);
		send_code(make_header(1'b0, 1'b1, 5), 1'b1);
		send_code(16'h0077, 1'b0);

		words_goal = sb.words_decoded + RANDOM_WORDS;
		phase_no   = 0;
		while (sb.words_decoded < words_goal) begin
			settle();
			program_setting(random_setting());
			calm = (phase_no == 2);
			if (phase_no == 4)
				hold_requests++;
			send_images($urandom_range(220, 80), phase_no == 0 || $urandom_range(9) < 7);
			phase_no++;
		end
		calm = 1'b0;
		settle();

		$display("sent %0d code words (%0d decoded) under %0d register settings, %0d spans checked",
			words_sent, sb.words_decoded, settings_used, sb.spans_checked);
		$display("covered both word formats, clipping, hidden and finished rows, and output stalls");
		if (sb.errors == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
design/rpcd_pkg.sv
design/rpcd_decode.sv
design/rle_pixmap_clip_decoder_top.sv
design/rpcd_checker.sv
bench/tb_top.sv
